// ===== src/fac_pkg.sv =====
`default_nettype none
package fac_pkg;

    localparam int STORE_DEPTH = 16;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int NIB_W       = 4;
    localparam int BYTE_W      = 8;

    typedef enum logic [NIB_W-1:0] {
        OP_LDA  = 4'h1,
        OP_LDB  = 4'h2,
        OP_ADD  = 4'h3,
        OP_SUB  = 4'h4,
        OP_MOV  = 4'h5,
        OP_JMP  = 4'h6,
        OP_JZ   = 4'h7,
        OP_JC   = 4'h8,
        OP_HALT = 4'h9
    } t_opcode;

    typedef enum logic {
        ACT_WRITE = 1'b0,
        ACT_STEP  = 1'b1
    } t_action;

    typedef struct packed {
        logic [NIB_W-1:0]  acc_a;
        logic [NIB_W-1:0]  reg_b;
        logic [ADDR_W-1:0] pc;
        logic              carry;
        logic              zero;
        logic              halt;
        logic              bad;
    } t_result;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] data;
    } t_store_wr;

endpackage
`default_nettype wire

// ===== src/fac_store.sv =====
`default_nettype none
module fac_store
    import fac_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_store_wr         i_wr,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [BYTE_W-1:0] o_rd_data
);

    logic [BYTE_W-1:0]      r_mem [STORE_DEPTH];
    logic [STORE_DEPTH-1:0] r_valid;
    logic [BYTE_W-1:0]      r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.en) begin
            r_valid[i_wr.addr] <= 1'b1;
        end
    end

    // Write-first: a write to the entry being read is forwarded.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_data <= '0;
        end else if (i_wr.en && (i_wr.addr == i_rd_addr)) begin
            r_rd_data <= i_wr.data;
        end else if (r_valid[i_rd_addr]) begin
            r_rd_data <= r_mem[i_rd_addr];
        end else begin
            r_rd_data <= '0;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

// ===== src/fac_core.sv =====
`default_nettype none
module fac_core
    import fac_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_step,
    input  wire logic [BYTE_W-1:0] i_instr,
    output logic      [ADDR_W-1:0] o_fetch_addr,
    output t_result                o_result
);

    logic [NIB_W-1:0]  r_a, n_a;
    logic [NIB_W-1:0]  r_b, n_b;
    logic [ADDR_W-1:0] r_pc, n_pc;
    logic              r_c, n_c;
    logic              r_z, n_z;
    logic              r_halt, n_halt;
    logic              r_bad, n_bad;

    logic [NIB_W:0]    w_sum;
    logic [NIB_W:0]    w_diff;
    logic [NIB_W-1:0]  w_imm;

    assign w_sum  = {1'b0, r_a} + {1'b0, r_b};
    assign w_diff = {1'b0, r_a} - {1'b0, r_b};
    assign w_imm  = i_instr[NIB_W-1:0];

    always_comb begin
        n_a    = r_a;
        n_b    = r_b;
        n_pc   = r_pc;
        n_c    = r_c;
        n_z    = r_z;
        n_halt = r_halt;
        n_bad  = r_bad;
        if (i_step && !r_halt) begin
            n_pc = r_pc + 1'b1;
            case (t_opcode'(i_instr[BYTE_W-1:NIB_W]))
                OP_LDA: begin
                    n_a = w_imm;
                end
                OP_LDB: begin
                    n_b = w_imm;
                end
                OP_ADD: begin
                    n_a = w_sum[NIB_W-1:0];
                    n_c = w_sum[NIB_W];
                    n_z = (w_sum[NIB_W-1:0] == '0);
                end
                OP_SUB: begin
                    n_a = w_diff[NIB_W-1:0];
                    n_c = w_diff[NIB_W];
                    n_z = (w_diff[NIB_W-1:0] == '0);
                end
                OP_MOV: begin
                    n_b = r_a;
                end
                OP_JMP: begin
                    n_pc = w_imm[ADDR_W-1:0];
                end
                OP_JZ: begin
                    if (r_z) begin
                        n_pc = w_imm[ADDR_W-1:0];
                    end
                end
                OP_JC: begin
                    if (r_c) begin
                        n_pc = w_imm[ADDR_W-1:0];
                    end
                end
                OP_HALT: begin
                    n_halt = 1'b1;
                end
                default: begin
                    n_halt = 1'b1;
                    n_bad  = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a    <= '0;
            r_b    <= '0;
            r_pc   <= '0;
            r_c    <= 1'b0;
            r_z    <= 1'b0;
            r_halt <= 1'b0;
            r_bad  <= 1'b0;
        end else begin
            r_a    <= n_a;
            r_b    <= n_b;
            r_pc   <= n_pc;
            r_c    <= n_c;
            r_z    <= n_z;
            r_halt <= n_halt;
            r_bad  <= n_bad;
        end
    end

    // The store is read at the next counter value, so the following
    // instruction is ready in the next cycle.
    assign o_fetch_addr = n_pc;

    always_comb begin
        o_result.acc_a = n_a;
        o_result.reg_b = n_b;
        o_result.pc    = n_pc;
        o_result.carry = n_c;
        o_result.zero  = n_z;
        o_result.halt  = n_halt;
        o_result.bad   = n_bad;
    end

endmodule
`default_nettype wire

// ===== src/fac_skid.sv =====
`default_nettype none
module fac_skid
    import fac_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_data,
    input  wire logic    i_out_stall,
    output logic         o_out_valid,
    output t_result      o_out_data,
    output logic         o_in_stall
);

    logic    r_main_valid;
    logic    r_skid_valid;
    t_result r_main;
    t_result r_skid;
    logic    w_free;

    assign w_free = !r_main_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_free) begin
            r_main_valid <= r_skid_valid || i_push;
            r_skid_valid <= 1'b0;
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_free) begin
            if (r_skid_valid) begin
                r_main <= r_skid;
            end else if (i_push) begin
                r_main <= i_data;
            end
        end else if (i_push) begin
            r_skid <= i_data;
        end
    end

    assign o_out_valid = r_main_valid;
    assign o_out_data  = r_main;
    assign o_in_stall  = r_skid_valid;

endmodule
`default_nettype wire

// ===== src/four_bit_accumulator_cpu.sv =====
// Four-bit accumulator CPU with a sixteen-byte program store.
// Input channel: i_in_valid / o_in_stall carries one transaction with
// i_action, i_address and i_data. A write transaction stores i_data at
// i_address; a step transaction executes the instruction at the program
// counter. Output channel: o_out_valid / i_out_stall returns one transaction
// per input transaction with the register and flag state after it.
// Each result is registered in the skid buffer, and one transaction is
// accepted every cycle while o_in_stall is low. The instruction at the next
// program counter is read from the store in the same cycle that an instruction
// executes, with writes to that entry forwarded, so steps run back to back.
// When the receiver stalls, one more result is held in a skid stage and
// o_in_stall rises only once that stage is full. Reset clears the registers,
// flags and store valid bits, so unwritten entries read as zero; no clearing
// pass is needed and a transaction can be accepted right after reset.
`default_nettype none
module four_bit_accumulator_cpu
    import fac_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic              i_action,
    input  wire logic [ADDR_W-1:0] i_address,
    input  wire logic [BYTE_W-1:0] i_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic      [NIB_W-1:0]  o_acc_a,
    output logic      [NIB_W-1:0]  o_reg_b,
    output logic      [ADDR_W-1:0] o_prog_counter,
    output logic                   o_carry_out,
    output logic                   o_zero_out,
    output logic                   o_halted_out,
    output logic                   o_bad_opcode
);

    logic              w_accept;
    logic              w_step;
    t_store_wr         w_wr;
    logic [ADDR_W-1:0] w_fetch_addr;
    logic [BYTE_W-1:0] w_instr;
    t_result           w_res;
    t_result           w_out;

    assign w_accept = i_in_valid && !o_in_stall;
    assign w_step   = w_accept && (t_action'(i_action) == ACT_STEP);

    always_comb begin
        w_wr.en   = w_accept && (t_action'(i_action) == ACT_WRITE);
        w_wr.addr = i_address;
        w_wr.data = i_data;
    end

    fac_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (w_wr),
        .i_rd_addr (w_fetch_addr),
        .o_rd_data (w_instr)
    );

    fac_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (w_step),
        .i_instr      (w_instr),
        .o_fetch_addr (w_fetch_addr),
        .o_result     (w_res)
    );

    fac_skid u_skid (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_accept),
        .i_data      (w_res),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (w_out),
        .o_in_stall  (o_in_stall)
    );

    assign o_acc_a        = w_out.acc_a;
    assign o_reg_b        = w_out.reg_b;
    assign o_prog_counter = w_out.pc;
    assign o_carry_out    = w_out.carry;
    assign o_zero_out     = w_out.zero;
    assign o_halted_out   = w_out.halt;
    assign o_bad_opcode   = w_out.bad;

    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with no result waiting");

    a_bad_implies_halt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && w_res.bad |-> w_res.halt)
        else $error("bad opcode mark without halt");

    a_halt_freezes_pc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && $past(w_accept) && $past(w_res.halt) && $past(i_rst_n)
        |-> (w_res.pc == $past(w_res.pc)) && w_res.halt)
        else $error("program counter moved while halted");

endmodule
`default_nettype wire
